/* hw/rtl/specular_removal_pixel_top_defines.svh */
// assertion macros for the checker file of the specular removal block
// no dependencies; included by spr_check.sv
`ifndef SPECULAR_REMOVAL_PIXEL_TOP_DEFINES_SVH
`define SPECULAR_REMOVAL_PIXEL_TOP_DEFINES_SVH

// concurrent check, quiet while reset is asserted
`define SPR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define SPR_ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/spr_pkg.sv */
// types, widths, register codes and the divider step of the specular removal block
// no dependencies; used by every module of the block
package spr_pkg;

	// chromaticity fraction bits
	localparam int unsigned CHROM_FRAC_BITS = 15;

	localparam int unsigned CH_W   = 8;
	localparam int unsigned CHR_W  = 16;
	localparam int unsigned SUM_W  = 10;
	localparam int unsigned DIFF_W = SUM_W;
	localparam int unsigned N_W    = 9;
	localparam int unsigned LANES  = 3;
	localparam int unsigned Q_W    = CH_W;

	// 3*chroma and scaled t1
	localparam int unsigned C3_W   = CHR_W + 2;
	localparam int unsigned T_W    = C3_W;
	localparam int unsigned TCMP_W = (CHROM_FRAC_BITS + 1 > C3_W) ? CHROM_FRAC_BITS + 1 : C3_W;
	localparam logic [TCMP_W-1:0] CHR_ONE = {{(TCMP_W-1){1'b0}}, 1'b1} << CHROM_FRAC_BITS;

	// near zero compare
	localparam int unsigned DT_W   = 8;
	localparam int unsigned ZT_W   = 16;
	localparam int unsigned NZ_SH  = 15;
	localparam int unsigned TM_W   = T_W + CH_W;
	localparam int unsigned ZS_W   = ZT_W + SUM_W;
	localparam int unsigned NZ_W   = ((TM_W > ZS_W) ? TM_W : ZS_W)
		+ ((NZ_SH > CHROM_FRAC_BITS) ? NZ_SH : CHROM_FRAC_BITS);

	// channel numerator and divider
	localparam int unsigned PROD_W = DIFF_W + T_W + 1;
	localparam int unsigned NT_W   = N_W + CHROM_FRAC_BITS;
	localparam int unsigned NUM_W  = ((PROD_W > NT_W) ? PROD_W : NT_W) + 1;
	localparam int unsigned DIV_W  = NUM_W + 1;
	localparam int unsigned V_W    = T_W + 3;
	localparam int unsigned REM_W  = (DIV_W > V_W + Q_W) ? DIV_W : V_W + Q_W;

	// register port
	localparam int unsigned NUM_REGS  = 2;
	localparam int unsigned ADDR_W    = $clog2(4 * NUM_REGS);
	localparam int unsigned REG_IDX_W = ADDR_W - 2;
	localparam int unsigned DATA_W    = 32;
	localparam logic [DT_W-1:0] DARK_RST = 8'd20;
	localparam logic [ZT_W-1:0] ZERO_RST = 16'd1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DARK = 1'b0,
		REG_ZERO = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_DARK      = 2'd0,
		ST_NOPOS     = 2'd1,
		ST_NEAR_ZERO = 2'd2,
		ST_SEP       = 2'd3
	} status_t;

	typedef struct packed {
		logic [CH_W-1:0]  red_in;
		logic [CH_W-1:0]  green_in;
		logic [CH_W-1:0]  blue_in;
		logic [CHR_W-1:0] max_chroma;
	} pix_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
		logic [1:0]      case_status;
	} res_t;

	typedef struct packed {
		logic [DT_W-1:0] dark;
		logic [ZT_W-1:0] zero;
	} cfg_t;

	// lane 0 red, 1 green, 2 blue
	typedef logic [LANES-1:0][CH_W-1:0] rgb_t;

	// front end result, dividend per lane and shared divisor 6*t
	typedef struct packed {
		rgb_t                        pix;
		status_t                     status;
		logic [V_W-1:0]              v;
		logic [LANES-1:0]            pos;
		logic [LANES-1:0][DIV_W-1:0] d;
	} sep_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   q;
		logic             sat;
		logic             pos;
	} lane_t;

	typedef struct packed {
		rgb_t                    pix;
		status_t                 status;
		logic [V_W-1:0]          v;
		lane_t [LANES-1:0]       lane;
	} divst_t;

	// one restoring step: quotient bit sh
	function automatic lane_t div_step(input lane_t ln, input logic [V_W-1:0] v,
		input int unsigned sh);
		lane_t            r;
		logic [REM_W-1:0] dv;
		r  = ln;
		dv = REM_W'(v) << sh;
		if (!ln.sat && ln.rem >= dv) begin
			r.rem = ln.rem - dv;
			r.q   = ln.q | (Q_W'(1) << sh);
		end
		return r;
	endfunction

endpackage

/* hw/rtl/spr_regs.sv */
// apb-style register file: dark threshold and zero threshold
// depends on spr_pkg
module spr_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spr_pkg::ADDR_W-1:0]   paddr,
	input  logic [spr_pkg::DATA_W-1:0]   pwdata,
	output logic [spr_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output spr_pkg::cfg_t                cfg
);

	logic [spr_pkg::DT_W-1:0] dark_q;
	logic [spr_pkg::ZT_W-1:0] zero_q;
	spr_pkg::reg_idx_t        idx;
	logic                     wr;

	assign idx    = spr_pkg::reg_idx_t'(paddr[spr_pkg::ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q <= spr_pkg::DARK_RST;
			zero_q <= spr_pkg::ZERO_RST;
		end else if (wr) begin
			case (idx)
				spr_pkg::REG_DARK: dark_q <= pwdata[spr_pkg::DT_W-1:0];
				spr_pkg::REG_ZERO: zero_q <= pwdata[spr_pkg::ZT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			spr_pkg::REG_DARK: prdata = spr_pkg::DATA_W'(dark_q);
			spr_pkg::REG_ZERO: prdata = spr_pkg::DATA_W'(zero_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.dark = dark_q;
	assign cfg.zero = zero_q;

endmodule

/* hw/rtl/spr_front.sv */
// front end, three stages: max/sum/t1, products, case decision and dividends
// depends on spr_pkg
module spr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  spr_pkg::cfg_t cfg,
	input  logic          pix_valid,
	output logic          pix_ready,
	input  spr_pkg::pix_t pix,
	output logic          sep_valid,
	input  logic          sep_ready,
	output spr_pkg::sep_t sep
);

	// stage 1 inputs
	spr_pkg::rgb_t                 ch_in;
	logic [spr_pkg::CH_W-1:0]      mx_in;
	logic [spr_pkg::SUM_W-1:0]     sum_in;
	logic [spr_pkg::C3_W-1:0]      c3_in;
	logic [spr_pkg::TCMP_W-1:0]    tdiff_in;
	logic                          tpos_in;

	logic                          vld_s1;
	spr_pkg::rgb_t                 pix_s1;
	logic [spr_pkg::CH_W-1:0]      mx_s1;
	logic [spr_pkg::SUM_W-1:0]     sum_s1;
	logic [spr_pkg::T_W-1:0]       t_s1;
	logic                          tpos_s1;
	logic                          dark_s1;

	// stage 2 inputs
	logic signed [spr_pkg::DIFF_W-1:0] diff [spr_pkg::LANES];
	logic signed [spr_pkg::PROD_W-1:0] prod [spr_pkg::LANES];
	logic [spr_pkg::SUM_W-1:0]         n3;
	logic [spr_pkg::NT_W-1:0]          nterm;
	logic [spr_pkg::TM_W-1:0]          lhs;
	logic [spr_pkg::ZS_W-1:0]          rhs;

	logic                              vld_s2;
	spr_pkg::rgb_t                     pix_s2;
	logic [spr_pkg::T_W-1:0]           t_s2;
	logic                              tpos_s2;
	logic                              dark_s2;
	logic [spr_pkg::TM_W-1:0]          lhs_s2;
	logic [spr_pkg::ZS_W-1:0]          rhs_s2;
	logic signed [spr_pkg::PROD_W-1:0] prod_s2 [spr_pkg::LANES];
	logic [spr_pkg::NT_W-1:0]          nterm_s2;

	// stage 3 inputs
	logic                          nz;
	logic [spr_pkg::NUM_W-1:0]     num [spr_pkg::LANES];
	logic [spr_pkg::V_W-1:0]       t3;
	spr_pkg::sep_t                 sep_nxt;

	logic                          vld_s3;
	spr_pkg::sep_t                 sep_s3;

	logic en1, en2, en3;

	assign en3       = !vld_s3 || sep_ready;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign pix_ready = en1;

	// stage 1: max, sum, t1 and its sign
	always_comb begin
		ch_in[0] = pix.red_in;
		ch_in[1] = pix.green_in;
		ch_in[2] = pix.blue_in;
		mx_in = pix.red_in;
		if (pix.green_in > mx_in) mx_in = pix.green_in;
		if (pix.blue_in > mx_in) mx_in = pix.blue_in;
		sum_in = spr_pkg::SUM_W'(pix.red_in) + spr_pkg::SUM_W'(pix.green_in)
			+ spr_pkg::SUM_W'(pix.blue_in);
		c3_in = spr_pkg::C3_W'(pix.max_chroma) + spr_pkg::C3_W'({pix.max_chroma, 1'b0});
		tdiff_in = spr_pkg::TCMP_W'(c3_in) - spr_pkg::CHR_ONE;
		tpos_in  = spr_pkg::TCMP_W'(c3_in) > spr_pkg::CHR_ONE;
	end

	// stage 2: per-lane products, near zero products, n term
	always_comb begin
		for (int l = 0; l < spr_pkg::LANES; l++) begin
			diff[l] = spr_pkg::DIFF_W'(pix_s1[l]) + spr_pkg::DIFF_W'({pix_s1[l], 1'b0}) - sum_s1;
			prod[l] = diff[l] * $signed({1'b0, t_s1});
		end
		n3    = spr_pkg::SUM_W'(mx_s1) + spr_pkg::SUM_W'({mx_s1, 1'b0}) - sum_s1;
		nterm = spr_pkg::NT_W'(n3[spr_pkg::N_W-1:0]) << spr_pkg::CHROM_FRAC_BITS;
		lhs   = spr_pkg::TM_W'(t_s1) * spr_pkg::TM_W'(mx_s1);
		rhs   = spr_pkg::ZS_W'(cfg.zero) * spr_pkg::ZS_W'(sum_s1);
	end

	// stage 3: case decision, numerators, dividend 2*num + 3*t and divisor 6*t
	always_comb begin
		nz = (spr_pkg::NZ_W'(lhs_s2) << spr_pkg::NZ_SH)
			< (spr_pkg::NZ_W'(rhs_s2) << spr_pkg::CHROM_FRAC_BITS);
		t3 = spr_pkg::V_W'(t_s2) + spr_pkg::V_W'({t_s2, 1'b0});
		sep_nxt.pix = pix_s2;
		sep_nxt.v   = spr_pkg::V_W'({t_s2, 1'b0}) + spr_pkg::V_W'({t_s2, 2'b0});
		for (int l = 0; l < spr_pkg::LANES; l++) begin
			num[l] = spr_pkg::NUM_W'(prod_s2[l]) + spr_pkg::NUM_W'(nterm_s2);
			sep_nxt.pos[l] = !num[l][spr_pkg::NUM_W-1] && (num[l] != '0);
			sep_nxt.d[l] = {1'b0, num[l][spr_pkg::NUM_W-2:0], 1'b0} + spr_pkg::DIV_W'(t3);
		end
		if (dark_s2) begin
			sep_nxt.status = spr_pkg::ST_DARK;
		end else if (!tpos_s2) begin
			sep_nxt.status = spr_pkg::ST_NOPOS;
		end else if (nz) begin
			sep_nxt.status = spr_pkg::ST_NEAR_ZERO;
		end else begin
			sep_nxt.status = spr_pkg::ST_SEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= pix_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && pix_valid) begin
			pix_s1  <= ch_in;
			mx_s1   <= mx_in;
			sum_s1  <= sum_in;
			t_s1    <= tdiff_in[spr_pkg::T_W-1:0];
			tpos_s1 <= tpos_in;
			dark_s1 <= mx_in <= cfg.dark;
		end
		if (en2 && vld_s1) begin
			pix_s2   <= pix_s1;
			t_s2     <= t_s1;
			tpos_s2  <= tpos_s1;
			dark_s2  <= dark_s1;
			lhs_s2   <= lhs;
			rhs_s2   <= rhs;
			prod_s2  <= prod;
			nterm_s2 <= nterm;
		end
		if (en3 && vld_s2) begin
			sep_s3 <= sep_nxt;
		end
	end

	assign sep_valid = vld_s3;
	assign sep       = sep_s3;

endmodule

/* hw/rtl/spr_div.sv */
// pipelined restoring divider, three lanes in lockstep, one quotient bit a stage
// depends on spr_pkg
module spr_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sep_valid,
	output logic            sep_ready,
	input  spr_pkg::sep_t   sep,
	output logic            q_valid,
	input  logic            q_ready,
	output spr_pkg::divst_t q
);

	localparam int unsigned NSTG = spr_pkg::Q_W + 1;

	spr_pkg::divst_t div_s [NSTG];
	spr_pkg::divst_t nxt   [NSTG];
	logic            vld_s [NSTG];
	logic            en    [NSTG];

	// stage 0: saturation check, quotient of 256 or more
	always_comb begin
		nxt[0].pix    = sep.pix;
		nxt[0].status = sep.status;
		nxt[0].v      = sep.v;
		for (int l = 0; l < spr_pkg::LANES; l++) begin
			nxt[0].lane[l].rem = spr_pkg::REM_W'(sep.d[l]);
			nxt[0].lane[l].q   = '0;
			nxt[0].lane[l].pos = sep.pos[l];
			nxt[0].lane[l].sat = spr_pkg::REM_W'(sep.d[l])
				>= (spr_pkg::REM_W'(sep.v) << spr_pkg::Q_W);
		end
	end

	for (genvar j = 1; j < NSTG; j++) begin : g_step
		always_comb begin
			nxt[j] = div_s[j-1];
			for (int l = 0; l < spr_pkg::LANES; l++) begin
				nxt[j].lane[l] = spr_pkg::div_step(div_s[j-1].lane[l], div_s[j-1].v,
					spr_pkg::Q_W - j);
			end
		end
	end

	for (genvar j = 0; j < NSTG; j++) begin : g_stage
		logic vin;

		if (j == NSTG - 1) begin : g_last
			assign en[j] = !vld_s[j] || q_ready;
		end else begin : g_mid
			assign en[j] = !vld_s[j] || en[j+1];
		end

		if (j == 0) begin : g_first
			assign vin = sep_valid;
		end else begin : g_next
			assign vin = vld_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en[j]) begin
				vld_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j] && vin) begin
				div_s[j] <= nxt[j];
			end
		end
	end

	assign sep_ready = en[0];
	assign q_valid   = vld_s[NSTG-1];
	assign q         = div_s[NSTG-1];

endmodule

/* hw/rtl/specular_removal_pixel_top.sv */
// top level of the specular highlight removal pixel pipeline
// depends on spr_pkg, spr_regs, spr_front, spr_div
//
// one pixel beat in, one result beat out, in order, one beat per clock when neither
// side stalls. the pipe holds three front-end stages (max/sum/t1, the
// 10x19 channel products and near zero products, case decision and dividends), nine
// divider stages (a saturation check plus one quotient bit for each of the eight
// result bits, three channel lanes side by side) and the output register. the
// divider is what sets the depth. every stage has its own valid bit and takes a new
// beat whenever it is empty or its successor moves, so bubbles close up under a
// stalled output and pix_ready falls only once the whole pipe is full. a dark
// pixel, a pixel with t1 not above zero and a near zero pixel pass through untouched
// with their case in case_status. the two thresholds sit on the apb port (dark at
// 0x0, zero at 0x4); write them only while no beat is in flight
module specular_removal_pixel_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// pixel channel
	input  logic                       pix_valid,
	output logic                       pix_ready,
	input  spr_pkg::pix_t              pix,
	// result channel
	output logic                       res_valid,
	input  logic                       res_ready,
	output spr_pkg::res_t              res,
	// register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [spr_pkg::ADDR_W-1:0] paddr,
	input  logic [spr_pkg::DATA_W-1:0] pwdata,
	output logic [spr_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	spr_pkg::cfg_t   cfg;
	logic            sep_valid;
	logic            sep_ready;
	spr_pkg::sep_t   sep;
	logic            q_valid;
	logic            q_ready;
	spr_pkg::divst_t q;

	// output register
	logic            res_valid_q;
	spr_pkg::res_t   res_q;
	spr_pkg::res_t   res_nxt;
	spr_pkg::rgb_t   ob;
	logic            en_out;

	spr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// thresholds, t1, products, dividends
	spr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.sep_valid (sep_valid),
		.sep_ready (sep_ready),
		.sep       (sep)
	);

	// per-channel quotient (2*num + 3*t) / (6*t), i.e. rounded half up
	spr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.sep_valid (sep_valid),
		.sep_ready (sep_ready),
		.sep       (sep),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q         (q)
	);

	assign en_out  = !res_valid_q || res_ready;
	assign q_ready = en_out;

	// pick diffuse value or passthrough; clamp low on a non-positive numerator, high on saturation
	always_comb begin
		for (int l = 0; l < spr_pkg::LANES; l++) begin
			if (q.status != spr_pkg::ST_SEP) begin
				ob[l] = q.pix[l];
			end else if (!q.lane[l].pos) begin
				ob[l] = '0;
			end else if (q.lane[l].sat) begin
				ob[l] = '1;
			end else begin
				ob[l] = q.lane[l].q;
			end
		end
		res_nxt.red_out     = ob[0];
		res_nxt.green_out   = ob[1];
		res_nxt.blue_out    = ob[2];
		res_nxt.case_status = q.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_out) begin
			res_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && q_valid) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* hw/rtl/spr_check.sv */
// port-level checks of the specular removal block, bound to the top level
// depends on spr_pkg and specular_removal_pixel_top_defines.svh
`include "specular_removal_pixel_top_defines.svh"

module spr_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pix_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input spr_pkg::res_t              res,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [spr_pkg::ADDR_W-1:0] paddr,
	input logic [spr_pkg::DATA_W-1:0] pwdata,
	input logic [spr_pkg::DATA_W-1:0] prdata
);

	// a free output side means every stage can move
	`SPR_ASSERT(a_ready_chain, clk, arst_n, res_ready |-> pix_ready, "pix_ready low while res_ready high")

	// a stalled result beat holds
	`SPR_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(res), "result beat dropped or changed under stall")

	// dark threshold reads back what was just written
	`SPR_ASSERT(a_dark_rdback, clk, arst_n, (psel && penable && pwrite && paddr[spr_pkg::ADDR_W-1:2] == spr_pkg::REG_DARK) ##1 (psel && penable && !pwrite && paddr[spr_pkg::ADDR_W-1:2] == spr_pkg::REG_DARK) |-> prdata[spr_pkg::DT_W-1:0] == $past(pwdata[spr_pkg::DT_W-1:0]), "dark threshold readback mismatch")

	// nothing comes out while in reset, valid is still unset before the first edge
	`SPR_ASSERT_RST(a_reset_quiet, clk, !arst_n |-> res_valid !== 1'b1, "result beat during reset")

endmodule

bind specular_removal_pixel_top spr_check u_check (.*);
